// File: rtl/rrbm_pkg.sv
// rrbm_pkg: shared types and constants for the rom/ram bank mapper
// holds the access kind codes, register indexes and the result record
// no dependencies
`default_nettype none

package rrbm_pkg;

    // configuration register indexes
    localparam int CfgIndexWidth = 1;
    localparam int CfgDataWidth  = 3;
    localparam logic [CfgIndexWidth-1:0] CFG_ROM_BANK_BITS  = 1'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_RAM_BANK_COUNT = 1'd1;

    // configuration reset values
    localparam logic [2:0] ROM_BANK_BITS_RESET  = 3'd1;
    localparam logic [2:0] RAM_BANK_COUNT_RESET = 3'd0;

    // fixed read values and the ram enable key
    localparam logic [7:0] BYTE_RAM_OFF   = 8'hFF;
    localparam logic [7:0] BYTE_UNMAPPED  = 8'h0F;
    localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

    // stream payload widths
    localparam int InDataWidth  = 24;
    localparam int OutDataWidth = 56;

    // classification of one bus transaction
    typedef enum logic [2:0] {
        KIND_FIXED     = 3'd0,
        KIND_ROM       = 3'd1,
        KIND_RAM_READ  = 3'd2,
        KIND_RAM_WRITE = 3'd3,
        KIND_OTHER     = 3'd4
    } access_kind_t;

    // one result item
    typedef struct packed {
        logic        ram_written;
        logic [7:0]  fixed_byte;
        logic [7:0]  write_byte;
        logic [14:0] ram_address;
        logic [20:0] rom_address;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/rom_ram_bank_mapper.sv
// rom_ram_bank_mapper: cartridge bank controller, top level
// decodes bus transactions into rom/ram addresses and updates bank registers
// depends on rrbm_pkg
`default_nettype none

// Usage
// - s_ channel: one bus transaction per item; s_tuser is the access type
//   (0 read, 1 write), s_tdata carries the address and the data byte.
// - m_ channel: exactly one result per transaction, in order; m_tuser is the
//   access kind, m_tdata carries the rom/ram addresses, bytes and the sticky
//   ram written flag (value after the transaction).
// - cfg port: rom bank bits (index 0) and ram bank count (index 1), written
//   whenever cfg_wr_en is high; only write it with the block idle.
// - path: an accepted transaction is held in the input register, decoded from it
//   and written to the result register when that register is free or draining;
//   m_tvalid then rises.
// - throughput: one transaction per cycle while m_tready stays high, set by the single
//   decode stage between the input register and the result register.
// - when m_tready is low the result register holds, the input register still
//   takes one more transaction, then s_tready drops until the result leaves.
// - reset (aresetn low, synchronous) empties both registers and returns the
//   bank state to rom bank 1, ram bank 0, simple mode, ram disabled, flag clear.
module rom_ram_bank_mapper
    import rrbm_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    // configuration write port
    input  wire logic                     cfg_wr_en,
    input  wire logic [CfgIndexWidth-1:0] cfg_index,
    input  wire logic [CfgDataWidth-1:0]  cfg_wdata,
    // bus transactions in
    input  wire logic                     s_tvalid,
    output      logic                     s_tready,
    input  wire logic [InDataWidth-1:0]   s_tdata,   // address[15:0], data[23:16]
    input  wire logic                     s_tuser,   // func[0]
    // results out
    output      logic                     m_tvalid,
    input  wire logic                     m_tready,
    output      logic [OutDataWidth-1:0]  m_tdata,   // rom_address[20:0],
                                                     // ram_address[35:21],
                                                     // write_byte[43:36],
                                                     // fixed_byte[51:44],
                                                     // ram_written[52], zero[55:53]
    output      logic [2:0]               m_tuser    // access_kind[2:0]
);

    // configuration registers
    logic [2:0] rom_bank_bits_reg;
    logic [2:0] ram_bank_count_reg;

    // bank state
    logic [6:0] rom_bank_reg, rom_bank_next;
    logic [1:0] ram_bank_reg, ram_bank_next;
    logic       adv_mode_reg, adv_mode_next;
    logic       ram_en_reg, ram_en_next;
    logic       ram_dirty_reg, ram_dirty_next;

    // input register
    logic        in_valid_reg;
    logic        in_func_reg;
    logic [15:0] in_addr_reg;
    logic [7:0]  in_data_reg;

    // result register
    logic         out_valid_reg;
    access_kind_t out_kind_reg, out_kind_next;
    result_t      out_res_reg, out_res_next;

    logic advance;
    logic [6:0] bank_mask;
    logic [1:0] upper_mask;
    logic [4:0] low_bits;
    logic [6:0] rom_hi_bank;
    logic [6:0] rom_lo_bank;
    logic [1:0] ram_sel_bank;
    logic       in_ram_window;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rom_bank_bits_reg  <= ROM_BANK_BITS_RESET;
            ram_bank_count_reg <= RAM_BANK_COUNT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ROM_BANK_BITS:  rom_bank_bits_reg  <= cfg_wdata;
                CFG_RAM_BANK_COUNT: ram_bank_count_reg <= cfg_wdata;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_func_reg <= s_tuser;
            in_addr_reg <= s_tdata[15:0];
            in_data_reg <= s_tdata[23:16];
        end
    end

    // bank masks and helper selections
    assign bank_mask     = 7'((8'd1 << rom_bank_bits_reg) - 8'd1);
    assign upper_mask    = rom_bank_bits_reg[0] ? 2'b11 : 2'b01;
    assign low_bits      = (in_data_reg[4:0] == 5'd0) ? 5'd1 : in_data_reg[4:0];
    assign rom_lo_bank   = adv_mode_reg ? {rom_bank_reg[6:5], 5'd0} : 7'd0;
    assign rom_hi_bank   = (rom_bank_reg == 7'd0) ? 7'd1 : rom_bank_reg;
    assign ram_sel_bank  = adv_mode_reg ? ram_bank_reg : 2'd0;
    assign in_ram_window = (in_addr_reg[15:13] == 3'b101);

    // decode and state update
    always_comb begin
        rom_bank_next  = rom_bank_reg;
        ram_bank_next  = ram_bank_reg;
        adv_mode_next  = adv_mode_reg;
        ram_en_next    = ram_en_reg;
        ram_dirty_next = ram_dirty_reg;
        out_kind_next  = KIND_OTHER;
        out_res_next   = '0;

        if (!in_func_reg) begin
            // reads
            if (in_addr_reg[15:14] == 2'b00) begin
                out_kind_next            = KIND_ROM;
                out_res_next.rom_address = {rom_lo_bank, in_addr_reg[13:0]};
            end else if (in_addr_reg[15:14] == 2'b01) begin
                out_kind_next            = KIND_ROM;
                out_res_next.rom_address = {rom_hi_bank, in_addr_reg[13:0]};
            end else if (in_ram_window) begin
                if (!ram_en_reg) begin
                    out_kind_next           = KIND_FIXED;
                    out_res_next.fixed_byte = BYTE_RAM_OFF;
                end else begin
                    out_kind_next            = KIND_RAM_READ;
                    out_res_next.ram_address = {ram_sel_bank, in_addr_reg[12:0]};
                end
            end else begin
                out_kind_next           = KIND_FIXED;
                out_res_next.fixed_byte = BYTE_UNMAPPED;
            end
        end else begin
            // writes: controller registers below 0x8000, ram writes in 0xA000-0xBFFF
            unique case (in_addr_reg[15:13])
                3'b000: begin
                    ram_en_next = (in_data_reg[3:0] == RAM_ENABLE_KEY);
                end
                3'b001: begin
                    rom_bank_next = ({rom_bank_reg[6:5], low_bits}) & bank_mask;
                end
                3'b010: begin
                    if (rom_bank_bits_reg > 3'd5) begin
                        rom_bank_next = {in_data_reg[1:0] & upper_mask, rom_bank_reg[4:0]};
                    end
                    if (ram_bank_count_reg > 3'd1) begin
                        ram_bank_next = in_data_reg[1:0];
                    end
                end
                3'b011: begin
                    adv_mode_next = in_data_reg[0];
                end
                3'b101: begin
                    if (ram_en_reg) begin
                        out_kind_next            = KIND_RAM_WRITE;
                        out_res_next.ram_address = {ram_sel_bank, in_addr_reg[12:0]};
                        out_res_next.write_byte  = in_data_reg;
                        ram_dirty_next           = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        out_res_next.ram_written = ram_dirty_next;
    end

    // bank state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rom_bank_reg  <= 7'd1;
            ram_bank_reg  <= 2'd0;
            adv_mode_reg  <= 1'b0;
            ram_en_reg    <= 1'b0;
            ram_dirty_reg <= 1'b0;
        end else if (advance) begin
            rom_bank_reg  <= rom_bank_next;
            ram_bank_reg  <= ram_bank_next;
            adv_mode_reg  <= adv_mode_next;
            ram_en_reg    <= ram_en_next;
            ram_dirty_reg <= ram_dirty_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_kind_reg <= out_kind_next;
            out_res_reg  <= out_res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {3'b000, out_res_reg};

    // sticky flag never clears outside reset
    a_dirty_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_dirty_reg |=> ram_dirty_reg)
        else $error("ram written flag cleared");

    // a ram write result always reports the flag set
    a_write_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_kind_reg == KIND_RAM_WRITE)) |-> out_res_reg.ram_written)
        else $error("ram write without flag");

    // rom address only on rom reads
    a_rom_addr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_kind_reg != KIND_ROM)) |-> (out_res_reg.rom_address == '0))
        else $error("rom address on non rom result");

    // a stalled transaction in the input register stays there
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_addr_reg)))
        else $error("input register lost a transaction");

endmodule

`default_nettype wire

// File: verif/rrbm_checker.sv
`timescale 1ns / 1ps
// rrbm_checker: in-order scoreboard for the rom/ram bank mapper
// tracks the bank registers from the accepted bus transactions and checks every result
// depends on rrbm_pkg; instantiated beside the block by rom_ram_bank_mapper_tb
module rrbm_checker
    import rrbm_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_wr_en,
    input  wire logic [CfgIndexWidth-1:0] cfg_index,
    input  wire logic [CfgDataWidth-1:0]  cfg_wdata,
    input  wire logic                     s_tvalid,
    input  wire logic                     s_tready,
    input  wire logic [InDataWidth-1:0]   s_tdata,   // address[15:0], data[23:16]
    input  wire logic                     s_tuser,   // func[0]
    input  wire logic                     m_tvalid,
    input  wire logic                     m_tready,
    input  wire logic [OutDataWidth-1:0]  m_tdata,   // rom_address[20:0], ram_address[35:21],
                                                     // write_byte[43:36], fixed_byte[51:44],
                                                     // ram_written[52], zero[55:53]
    input  wire logic [2:0]               m_tuser,   // access_kind[2:0]
    output int                            mismatches,
    output int                            pending,
    output int                            compared
);

    // expected classification of one bus transaction
    typedef struct packed {
        access_kind_t kind;
        result_t      res;
    } mapping_t;

    // controller registers and bank state
    logic [2:0] bank_bits_cfg;
    logic [2:0] ram_banks_cfg;
    logic [6:0] rom_bank;
    logic [1:0] ram_bank;
    logic       adv_mode;
    logic       ram_on;
    logic       ram_dirty;

    mapping_t   expected_maps[$];

    initial begin
        mismatches = 0;
        pending    = 0;
        compared   = 0;
    end

    // physical external ram address, bank only counts in advanced mode
    function automatic logic [14:0] ram_offset(input logic [15:0] addr);
        return {(adv_mode ? ram_bank : 2'd0), addr[12:0]};
    endfunction

    // decode one access, update the bank registers, return the expected result
    function automatic mapping_t map_access(input logic wr, input logic [15:0] addr,
                                            input logic [7:0] data);
        mapping_t   r;
        logic [6:0] bank;
        logic [6:0] mask;
        logic [1:0] upper;
        r      = '0;
        r.kind = KIND_OTHER;
        if (!wr) begin
            if (addr < 16'h4000) begin
                bank = adv_mode ? (rom_bank & 7'h60) : 7'd0;
                r.kind = KIND_ROM;
                r.res.rom_address = {bank, addr[13:0]};
            end else if (addr < 16'h8000) begin
                // bank 0 in the switchable window reads as bank 1
                bank = (rom_bank != 7'd0) ? rom_bank : 7'd1;
                r.kind = KIND_ROM;
                r.res.rom_address = {bank, addr[13:0]};
            end else if (addr >= 16'hA000 && addr <= 16'hBFFF) begin
                if (!ram_on) begin
                    r.kind = KIND_FIXED;
                    r.res.fixed_byte = BYTE_RAM_OFF;
                end else begin
                    r.kind = KIND_RAM_READ;
                    r.res.ram_address = ram_offset(addr);
                end
            end else begin
                r.kind = KIND_FIXED;
                r.res.fixed_byte = BYTE_UNMAPPED;
            end
        end else begin
            if (addr <= 16'h1FFF) begin
                ram_on = (data[3:0] == RAM_ENABLE_KEY);
            end else if (addr <= 16'h3FFF) begin
                // low five bits, zero written as one, then cut to the rom size
                mask = 7'((8'd1 << bank_bits_cfg) - 8'd1);
                bank = {rom_bank[6:5], (data[4:0] == 5'd0) ? 5'd1 : data[4:0]};
                rom_bank = bank & mask;
            end else if (addr <= 16'h5FFF) begin
                // upper bank bits only exist above 32 banks
                if (bank_bits_cfg > 3'd5) begin
                    upper = (bank_bits_cfg == 3'd6) ? {1'b0, data[0]} : data[1:0];
                    rom_bank = {upper, rom_bank[4:0]};
                end
                if (ram_banks_cfg > 3'd1) begin
                    ram_bank = data[1:0];
                end
            end else if (addr <= 16'h7FFF) begin
                adv_mode = data[0];
            end else if (addr >= 16'hA000 && addr <= 16'hBFFF && ram_on) begin
                r.kind = KIND_RAM_WRITE;
                r.res.ram_address = ram_offset(addr);
                r.res.write_byte = data;
                ram_dirty = 1'b1;
            end
        end
        r.res.ram_written = ram_dirty;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // watch both channels and the register port at every edge
    always @(posedge aclk) begin
        mapping_t want;
        result_t  got;
        if (!aresetn) begin
            bank_bits_cfg = ROM_BANK_BITS_RESET;
            ram_banks_cfg = RAM_BANK_COUNT_RESET;
            rom_bank      = 7'd1;
            ram_bank      = 2'd0;
            adv_mode      = 1'b0;
            ram_on        = 1'b0;
            ram_dirty     = 1'b0;
            expected_maps.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_ROM_BANK_BITS) begin
                    bank_bits_cfg = cfg_wdata;
                end else if (cfg_index == CFG_RAM_BANK_COUNT) begin
                    ram_banks_cfg = cfg_wdata;
                end
            end
            // results first: a transaction cannot come out in the cycle it goes in
            if (m_tvalid && m_tready) begin
                got = m_tdata[52:0];
                if (expected_maps.size() == 0) begin
                    $error("result transaction with none outstanding: kind %0d", m_tuser);
                    mismatches++;
                end else begin
                    want = expected_maps.pop_front();
                    compare_field("access_kind", 32'(want.kind), 32'(m_tuser));
                    compare_field("rom_address", 32'(want.res.rom_address),
                                  32'(got.rom_address));
                    compare_field("ram_address", 32'(want.res.ram_address),
                                  32'(got.ram_address));
                    compare_field("write_byte", 32'(want.res.write_byte),
                                  32'(got.write_byte));
                    compare_field("fixed_byte", 32'(want.res.fixed_byte),
                                  32'(got.fixed_byte));
                    compare_field("ram_written", 32'(want.res.ram_written),
                                  32'(got.ram_written));
                    compared++;
                end
            end
            if (s_tvalid && s_tready) begin
                expected_maps.push_back(map_access(s_tuser, s_tdata[15:0], s_tdata[23:16]));
            end
        end
        pending = expected_maps.size();
    end

endmodule

// File: verif/rom_ram_bank_mapper_tb.sv
`timescale 1ns / 1ps
// rom_ram_bank_mapper_tb: top of the bank mapper testbench, stimulus and verdict
// drives bus transactions and bank settings, the checker in rrbm_checker compares
// depends on rrbm_pkg, rom_ram_bank_mapper and rrbm_checker
module rom_ram_bank_mapper_tb;
    import rrbm_pkg::*;

    localparam int STALL_LIMIT      = 1000;
    localparam int HOLD_CYCLES      = 120;
    localparam int SETTLE_CYCLES    = 4;
    localparam int PHASES           = 8;
    localparam int RANDOM_PER_PHASE = 92;
    // per phase settings, phase 0 in the lowest bits
    localparam logic [23:0] PHASE_BANK_BITS =
        {3'd2, 3'd7, 3'd3, 3'd1, 3'd5, 3'd0, 3'd6, 3'd7};
    localparam logic [23:0] PHASE_RAM_BANKS =
        {3'd6, 3'd3, 3'd5, 3'd0, 3'd1, 3'd7, 3'd2, 3'd4};

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_TOGGLE
    } drain_style_t;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [CfgIndexWidth-1:0] cfg_index = '0;
    logic [CfgDataWidth-1:0]  cfg_wdata = '0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [InDataWidth-1:0]   s_tdata   = '0;   // address[15:0], data[23:16]
    logic                     s_tuser   = 1'b0; // func[0]
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [OutDataWidth-1:0]  m_tdata;          // rom_address[20:0], ram_address[35:21],
                                                // write_byte[43:36], fixed_byte[51:44],
                                                // ram_written[52], zero[55:53]
    logic [2:0]               m_tuser;          // access_kind[2:0]

    int mismatches;
    int pending;
    int compared;
    int items_sent  = 0;
    int burst_left  = 0;
    int stall_count = 0;
    bit hold_req    = 1'b0;

    rom_ram_bank_mapper dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    rrbm_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .mismatches (mismatches),
        .pending    (pending),
        .compared   (compared)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_count <= 0;
        end else begin
            stall_count <= stall_count + 1;
            if (stall_count >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // result side back-pressure, plus one long hold-off on request
    initial begin
        drain_style_t style;
        int unsigned  len;
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                style = drain_style_t'($urandom_range(READY_ALWAYS, READY_TOGGLE));
                len   = $urandom_range(4, 40);
                repeat (len) begin
                    case (style)
                        READY_ALWAYS: m_tready <= 1'b1;
                        READY_COIN:   m_tready <= 1'($urandom_range(0, 1));
                        READY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                        default:      m_tready <= ~m_tready;
                    endcase
                    @(posedge aclk);
                end
            end
        end
    end

    // offer one bus transaction, in bursts with random gaps between them
    task automatic drive_access(input logic wr, input logic [15:0] addr,
                                input logic [7:0] data);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= wr;
        s_tdata  <= {data, addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        items_sent++;
    endtask

    // stop offering and wait for every outstanding result
    task automatic settle();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(input logic [2:0] bank_bits, input logic [2:0] ram_banks);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_ROM_BANK_BITS;
        cfg_wdata <= bank_bits;
        @(posedge aclk);
        cfg_index <= CFG_RAM_BANK_COUNT;
        cfg_wdata <= ram_banks;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // random access, weighted toward the register and ram windows
    task automatic random_access();
        int unsigned pick;
        logic        wr;
        logic [15:0] addr;
        logic [7:0]  data;
        pick = $urandom_range(0, 99);
        data = 8'($urandom);
        wr   = 1'($urandom_range(0, 1));
        if (pick < 8) begin
            wr   = 1'b1;
            addr = 16'($urandom_range(16'h0000, 16'h1FFF));
            if ($urandom_range(0, 2) != 0) begin
                data[3:0] = RAM_ENABLE_KEY;
            end
        end else if (pick < 18) begin
            wr   = 1'b1;
            addr = 16'($urandom_range(16'h2000, 16'h3FFF));
            if ($urandom_range(0, 4) == 0) begin
                data[4:0] = 5'd0;
            end
        end else if (pick < 26) begin
            wr   = 1'b1;
            addr = 16'($urandom_range(16'h4000, 16'h5FFF));
        end else if (pick < 32) begin
            wr   = 1'b1;
            addr = 16'($urandom_range(16'h6000, 16'h7FFF));
        end else if (pick < 50) begin
            addr = 16'($urandom_range(16'hA000, 16'hBFFF));
        end else if (pick < 80) begin
            wr   = 1'b0;
            addr = 16'($urandom_range(16'h0000, 16'h7FFF));
        end else begin
            addr = 16'($urandom);
        end
        drive_access(wr, addr, data);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: one rom bank bit, no ram banks
        drive_access(1'b0, 16'h0000, 8'h00);
        drive_access(1'b0, 16'h7FFF, 8'hFF);
        drive_access(1'b0, 16'hA000, 8'h00);
        drive_access(1'b1, 16'hA000, 8'h5A);
        drive_access(1'b0, 16'h8000, 8'h00);
        drive_access(1'b0, 16'hFFFF, 8'hFF);
        drive_access(1'b1, 16'h2000, 8'h00);
        drive_access(1'b1, 16'h3FFF, 8'h02);
        drive_access(1'b0, 16'h4000, 8'h00);
        settle();

        // largest rom and four ram banks: upper bits, advanced mode, ram traffic
        set_config(3'd7, 3'd4);
        drive_access(1'b1, 16'h0000, 8'h0A);
        drive_access(1'b1, 16'h3FFF, 8'h1F);
        drive_access(1'b1, 16'h4000, 8'h03);
        drive_access(1'b1, 16'h6000, 8'h01);
        drive_access(1'b0, 16'h3FFF, 8'h00);
        drive_access(1'b0, 16'h4000, 8'h00);
        drive_access(1'b0, 16'hBFFF, 8'h00);
        drive_access(1'b1, 16'hBFFF, 8'hFF);
        drive_access(1'b1, 16'hA000, 8'h00);
        drive_access(1'b1, 16'h7FFF, 8'hFE);
        drive_access(1'b0, 16'hA000, 8'h00);
        drive_access(1'b1, 16'h1FFF, 8'h1B);
        drive_access(1'b0, 16'hBFFF, 8'h00);
        drive_access(1'b1, 16'h9FFF, 8'h55);
        drive_access(1'b1, 16'hC000, 8'hAA);
        settle();

        // random phases over a spread of bank settings
        for (int p = 0; p < PHASES; p++) begin
            set_config(PHASE_BANK_BITS[p*3 +: 3], PHASE_RAM_BANKS[p*3 +: 3]);
            for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
                if (p == 0 && i == 40) begin
                    hold_req = 1'b1;
                end
                random_access();
            end
            settle();
        end

        $display("covered %0d bus transactions under %0d bank settings, %0d results compared",
                 items_sent, PHASES + 2, compared);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
